### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### rtl/core/mdr_pkg.sv
package mdr_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int DATA_W    = 64;
  localparam int IDX_W     = 6;
  localparam int SZ_W      = 7;
  localparam int DIV_W     = IDX_W + 1;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int IN_DATA_W = 88;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SZ_W-1:0]  divisor;
  } mdr_mod_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SZ_W-1:0] rem;
  } mdr_mod_rsp_t;

  // A size of zero behaves as one, a size above the maximum as the maximum.
  function automatic logic [SZ_W-1:0] clamp_size(logic [SZ_W-1:0] v, logic [SZ_W-1:0] max);
    logic [SZ_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SZ_W'(1);
    end else if (v > max) begin
      r = max;
    end
    return r;
  endfunction

endpackage

### rtl/core/mdr_modulo.sv
`include "assert_macros.svh"

// Restoring remainder unit: one dividend bit per cycle, MSB first.
module mdr_modulo
  import mdr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mdr_mod_req_t req_i,
  output mdr_mod_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SZ_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [SZ_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W-1:0] trial;

  assign trial = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (SZ_W'(trial) >= dvs_q) begin
        rem_d = SZ_W'(trial) - dvs_q;
      end else begin
        rem_d = SZ_W'(trial);
      end
      dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  `ASSERT_AT(a_rem_below_divisor, clk_i, rst_ni, done_q |-> (rem_q < dvs_q))
  `ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_q && busy_q)

endmodule

### rtl/core/matrix_diagonal_reorder_top.sv
// Diagonal-order matrix store.
// Items arrive on the s_axis channel. tuser selects the command: a load
// writes the 64-bit word of tdata at (load_row, load_col); a read returns
// the entry at row (j mod num_rows), column ((j + i) mod num_cols), with i
// the diagonal number and j the position along it. Results leave on the
// m_axis channel: tdata carries the word, tuser the error flag. A load in
// range gives no result; an out-of-range load or read gives one result with
// error set and a zero word. The sizes are written over the APB port.
// A load in range is written in the cycle after acceptance, and the sequencer
// then returns to idle. An out-of-range item goes from the range check to
// the output load and then frees the input. A read passes the range check,
// two remainders (a load and 7 steps each) on the shared bit-serial
// remainder unit, one memory read and the output load, then frees the input.
// s_axis_tready is high only while the sequencer idles.
// The result sits in an output register, so a new item is accepted while a
// result waits. If m_axis_tready stays low, the next result is held in the
// sequencer until the register frees up, and input stops meanwhile.
// Reset sets both sizes to 64 and empties the output register; the matrix
// memory is not cleared and an entry reads as garbage until it is loaded.
`include "assert_macros.svh"

module matrix_diagonal_reorder_top
  import mdr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] load_row, [11:6] load_col, [75:12] value, [81:76] diag_index,
  // [87:82] diag_pos
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // [0] command
  input  logic                 s_axis_tuser,
  // Result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [63:0] element
  output logic [DATA_W-1:0]    m_axis_tdata,
  // [0] error
  output logic                 m_axis_tuser
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MODR  = 6'b000100,
    ST_MODC  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SZ_W-1:0] num_rows_q, num_cols_q;
  logic [SZ_W-1:0] rows_eff, cols_eff;

  logic              cmd_q;
  logic [IDX_W-1:0]  a_q, b_q;
  logic [IDX_W-1:0]  ld_col_q;
  logic [DATA_W-1:0] value_q;
  logic              err_q, err_d;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] mem_q [MEM_DEPTH];

  logic              m_valid_q;
  logic [DATA_W-1:0] m_data_q;
  logic              m_err_q;

  logic         s_accept, cfg_wr, range_err, mem_we, out_load;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  mdr_mod_req_t mod_req;
  mdr_mod_rsp_t mod_rsp;

  // Configuration registers: bit 2 of the address picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= SZ_W'(MAX_ROWS);
      num_cols_q <= SZ_W'(MAX_COLS);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NUM_ROWS) begin
        num_rows_q <= pwdata[SZ_W-1:0];
      end else begin
        num_cols_q <= pwdata[SZ_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NUM_COLS) ? 32'(num_cols_q) : 32'(num_rows_q);

  assign rows_eff = clamp_size(num_rows_q, SZ_W'(MAX_ROWS));
  assign cols_eff = clamp_size(num_cols_q, SZ_W'(MAX_COLS));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Capture the item. For a load a_q/ld_col_q hold row/column; for a read
  // a_q/b_q hold the diagonal number and the position.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= s_axis_tuser;
      ld_col_q <= s_axis_tdata[11:6];
      value_q  <= s_axis_tdata[75:12];
      if (s_axis_tuser == CMD_LOAD) begin
        a_q <= s_axis_tdata[5:0];
      end else begin
        a_q <= s_axis_tdata[81:76];
      end
      b_q <= s_axis_tdata[87:82];
    end
  end

  // A load checks row and column; a read checks i against the row count
  // and j against the column count.
  always_comb begin
    if (cmd_q == CMD_LOAD) begin
      range_err = (SZ_W'(a_q) >= rows_eff) || (SZ_W'(ld_col_q) >= cols_eff);
    end else begin
      range_err = (SZ_W'(a_q) >= rows_eff) || (SZ_W'(b_q) >= cols_eff);
    end
  end

  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d          = state_q;
    err_d            = err_q;
    mem_we           = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = DIV_W'(b_q);
    mod_req.divisor  = rows_eff;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        err_d = range_err;
        if (range_err) begin
          state_d = ST_FIN;
        end else if (cmd_q == CMD_LOAD) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mod_req.start = 1'b1;
          state_d       = ST_MODR;
        end
      end
      ST_MODR: begin
        // Row done: start the column remainder of (j + i) right away.
        if (mod_rsp.done) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = DIV_W'(b_q) + DIV_W'(a_q);
          mod_req.divisor  = cols_eff;
          state_d          = ST_MODC;
        end
      end
      ST_MODC: begin
        if (mod_rsp.done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  mdr_modulo u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mod_rsp.done && (state_q == ST_MODR)) begin
      rrow_q <= mod_rsp.rem[ROW_W-1:0];
    end
    if (mod_rsp.done && (state_q == ST_MODC)) begin
      rcol_q <= mod_rsp.rem[COL_W-1:0];
    end
  end

  // Matrix memory: row-major, one write or one registered read per cycle.
  assign wr_addr = ADDR_W'(ADDR_W'(a_q[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(ld_col_q[COL_W-1:0]));
  assign rd_addr = ADDR_W'(ADDR_W'(rrow_q) * ADDR_W'(MAX_COLS) + ADDR_W'(rcol_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= value_q;
    end
    if (state_q == ST_RD) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= err_q ? '0 : rdata_q;
      m_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_err_q;

  `ASSERT_AT(a_result_from_fin, clk_i, rst_ni,
             $rose(m_valid_q) |-> $past(state_q == ST_FIN))
  `ASSERT_NEVER(a_no_accept_while_dividing, clk_i, rst_ni, mod_rsp.busy && s_axis_tready)
  `ASSERT_AT(a_error_word_zero, clk_i, rst_ni,
             (m_valid_q && m_err_q) |-> (m_data_q == '0))
  `ASSERT_NEVER(a_write_only_on_load, clk_i, rst_ni, mem_we && (cmd_q != CMD_LOAD))

endmodule

### sim/tb_matrix_diagonal_reorder_top.sv
`timescale 1ns / 100ps

module tb_matrix_diagonal_reorder_top
  import mdr_pkg::*;
();

  // An in-range load gives no result. This many quiet cycles after the last
  // result means the block is idle.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int NUM_PHASES    = 12;
  localparam int STEPS_PER_PHASE = 90;
  localparam int NUM_FIXED_SIZES = 10;

  // Size register values for the fixed phases. The list covers one by one,
  // full size, zero (which acts as one), values above the maximum, and
  // rectangular shapes in both directions. The last phases pick random values.
  localparam logic [6:0] PHASE_ROWS [NUM_FIXED_SIZES] =
    '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd5, 7'd7, 7'd12, 7'd64, 7'd1};
  localparam logic [6:0] PHASE_COLS [NUM_FIXED_SIZES] =
    '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd64, 7'd12, 7'd7, 7'd1, 7'd64};

  typedef struct {
    logic        cmd;
    logic [5:0]  load_row;
    logic [5:0]  load_col;
    logic [63:0] value;
    logic [5:0]  diag_index;
    logic [5:0]  diag_pos;
  } mdr_cmd_t;

  typedef struct {
    logic [63:0] element;
    logic        error;
  } diag_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;

  matrix_diagonal_reorder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Items waiting to be sent, and the results the block owes us.
  mdr_cmd_t     pending_cmds[$];
  diag_result_t expected_results[$];

  // Mirror of the block: the matrix words and the two size registers as the
  // bus last wrote them.
  logic [63:0] matrix_mirror [MAX_ROWS*MAX_COLS];
  logic [6:0]  mirror_rows_reg = 7'd64;
  logic [6:0]  mirror_cols_reg = 7'd64;

  // The stimulus side keeps its own view of which entries will have been
  // written by the time a read arrives, so that it never reads an entry
  // that holds no defined word yet.
  bit planned_written [MAX_ROWS*MAX_COLS];
  int plan_rows = 64;
  int plan_cols = 64;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int n_loads        = 0;
  int n_reads        = 0;
  int n_flagged      = 0;
  int n_checked      = 0;
  int n_settings     = 0;

  mdr_cmd_t     in_flight_cmd;
  diag_result_t head_result;

  // A size of zero acts as one and a size above the maximum as the maximum.
  function automatic int effective_size(input logic [6:0] v, input int max_size);
    if (v == 7'd0) return 1;
    if (int'(v) > max_size) return max_size;
    return int'(v);
  endfunction

  // Works out what the block answers for one accepted item and updates the
  // mirrored matrix.
  function automatic void predict_result(input mdr_cmd_t c);
    int rows;
    int cols;
    int row;
    int col;
    diag_result_t res;
    rows = effective_size(mirror_rows_reg, MAX_ROWS);
    cols = effective_size(mirror_cols_reg, MAX_COLS);
    res.element = '0;
    res.error = 1'b0;
    if (c.cmd == CMD_LOAD) begin
      n_loads++;
      if (int'(c.load_row) >= rows || int'(c.load_col) >= cols) begin
        res.error = 1'b1;
        expected_results = {expected_results, res};
      end else begin
        matrix_mirror[int'(c.load_row) * MAX_COLS + int'(c.load_col)] = c.value;
      end
    end else begin
      n_reads++;
      if (int'(c.diag_index) >= rows || int'(c.diag_pos) >= cols) begin
        res.error = 1'b1;
      end else begin
        row = int'(c.diag_pos) % rows;
        col = (int'(c.diag_pos) + int'(c.diag_index)) % cols;
        res.element = matrix_mirror[row * MAX_COLS + col];
      end
      expected_results = {expected_results, res};
    end
  endfunction

  function automatic logic [63:0] random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  // Fields that the command does not use still carry random bits.
  function automatic mdr_cmd_t random_cmd();
    mdr_cmd_t c;
    c.cmd        = 1'($urandom_range(0, 1));
    c.load_row   = 6'($urandom);
    c.load_col   = 6'($urandom);
    c.value      = {$urandom, $urandom};
    c.diag_index = 6'($urandom);
    c.diag_pos   = 6'($urandom);
    return c;
  endfunction

  function automatic void plan_load(input int row, input int col, input logic [63:0] word);
    mdr_cmd_t c;
    c = random_cmd();
    c.cmd = CMD_LOAD;
    c.load_row = 6'(row);
    c.load_col = 6'(col);
    c.value = word;
    if (row < plan_rows && col < plan_cols) planned_written[row * MAX_COLS + col] = 1'b1;
    pending_cmds = {pending_cmds, c};
  endfunction

  // An in-range read of an entry that is not yet written is preceded by a
  // load of that entry.
  function automatic void plan_read(input int diag_i, input int diag_j);
    mdr_cmd_t c;
    int row;
    int col;
    if (diag_i < plan_rows && diag_j < plan_cols) begin
      row = diag_j % plan_rows;
      col = (diag_j + diag_i) % plan_cols;
      if (!planned_written[row * MAX_COLS + col]) plan_load(row, col, random_word());
    end
    c = random_cmd();
    c.cmd = CMD_READ;
    c.diag_index = 6'(diag_i);
    c.diag_pos = 6'(diag_j);
    pending_cmds = {pending_cmds, c};
  endfunction

  // Picks a pair of indices with at least one outside the current size.
  // At full size nothing is out of range, so the pair stays in range.
  function automatic void pick_out_of_range(output int a, output int b);
    a = $urandom_range(0, 63);
    b = $urandom_range(0, 63);
    if (plan_rows < 64 && (plan_cols == 64 || $urandom_range(0, 1) == 1)) begin
      a = $urandom_range(plan_rows, 63);
    end else if (plan_cols < 64) begin
      b = $urandom_range(plan_cols, 63);
    end else begin
      a = $urandom_range(0, plan_rows - 1);
      b = $urandom_range(0, plan_cols - 1);
    end
  endfunction

  // One random step: mostly in-range loads and reads, with a share of
  // out-of-range loads and reads that must come back flagged.
  function automatic void plan_random_step();
    int roll;
    int a;
    int b;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      plan_load($urandom_range(0, plan_rows - 1), $urandom_range(0, plan_cols - 1),
                random_word());
    end else if (roll < 52) begin
      pick_out_of_range(a, b);
      plan_load(a, b, random_word());
    end else if (roll < 88) begin
      plan_read($urandom_range(0, plan_rows - 1), $urandom_range(0, plan_cols - 1));
    end else begin
      pick_out_of_range(a, b);
      plan_read(a, b);
    end
  endfunction

  // Driver: offers the next pending item unless this cycle is an idle one.
  // The item is predicted at the edge where the block accepts it.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) predict_result(in_flight_cmd);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_flight_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {in_flight_cmd.diag_pos, in_flight_cmd.diag_index,
                          in_flight_cmd.value, in_flight_cmd.load_col,
                          in_flight_cmd.load_row};
        s_axis_tuser  <= in_flight_cmd.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation
  // and stalls the result channel at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: element %h error %b",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        head_result = expected_results.pop_front();
        n_checked++;
        if (head_result.error) n_flagged++;
        if (m_axis_tdata !== head_result.element) begin
          $error("element mismatch: expected %h, actual %h", head_result.element, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== head_result.error) begin
          $error("error mismatch: expected %b, actual %b", head_result.error, m_axis_tuser);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // The mirrored size registers follow the writes seen on the bus.
  always @(posedge clk_i) begin
    if (psel && penable && pwrite && pready) begin
      if (paddr == {REG_NUM_ROWS, 2'b00}) mirror_rows_reg <= pwdata[6:0];
      if (paddr == {REG_NUM_COLS, 2'b00}) mirror_cols_reg <= pwdata[6:0];
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the word at the edge
  // that ends the access cycle. Bits above the register width are random.
  task automatic write_size_reg(input logic reg_sel, input logic [6:0] v);
    logic [31:0] word;
    word = $urandom;
    word[6:0] = v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_sizes(input logic [6:0] rows_v, input logic [6:0] cols_v);
    write_size_reg(REG_NUM_ROWS, rows_v);
    write_size_reg(REG_NUM_COLS, cols_v);
    plan_rows = effective_size(rows_v, MAX_ROWS);
    plan_cols = effective_size(cols_v, MAX_COLS);
    n_settings++;
  endtask

  // Waits until every item went out and every result came back, then lets
  // the block finish any load that gives no result.
  task automatic wait_until_idle();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at the reset size of 64 by 64: corner entries, extreme
    // words, wrap of the column past the last one, and an overwrite.
    plan_load(0, 0, '0);
    plan_load(63, 63, '1);
    plan_load(0, 63, 64'hA5A5_A5A5_A5A5_A5A5);
    plan_load(63, 0, 64'h5A5A_5A5A_5A5A_5A5A);
    plan_load(63, 62, 64'h8000_0000_0000_0001);
    plan_load(62, 63, random_word());
    plan_read(0, 0);
    plan_read(63, 63);
    plan_read(0, 63);
    plan_read(1, 63);
    plan_read(63, 0);
    plan_load(0, 0, '1);
    plan_read(0, 0);
    wait_until_idle();

    // Directed items at 3 by 5: loads and reads out of range on either
    // index, and reads where the row index wraps past the row count.
    set_sizes(7'd3, 7'd5);
    plan_load(2, 4, random_word());
    plan_load(3, 0, random_word());
    plan_load(0, 5, random_word());
    plan_load(63, 63, random_word());
    plan_read(3, 0);
    plan_read(0, 5);
    plan_read(63, 63);
    plan_read(2, 4);
    plan_read(0, 4);
    plan_read(1, 3);
    wait_until_idle();

    // Random phases, each with its own sizes and one of four idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED_SIZES) begin
        set_sizes(PHASE_ROWS[p], PHASE_COLS[p]);
      end else begin
        set_sizes(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
      endcase
      for (int k = 0; k < STEPS_PER_PHASE; k++) plan_random_step();
      wait_until_idle();
    end

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Sent %0d loads and %0d diagonal reads over %0d size settings.",
             n_loads, n_reads, n_settings + 1);
    $display("Checked %0d results, %0d of them flagged out of range.", n_checked, n_flagged);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mdr_pkg.sv
rtl/core/mdr_modulo.sv
rtl/core/matrix_diagonal_reorder_top.sv
sim/tb_matrix_diagonal_reorder_top.sv
